@@ rtl/core/fas_pkg.sv @@
// Shared constants for the fall alarm sequencer: field widths, register indexes and divider constants.
package fas_pkg;

	localparam int NowW   = 32;
	localparam int CfgW   = 22;
	localparam int PreW   = 20;
	localparam int MsgW   = 20;
	localparam int DispW  = 22;
	localparam int CountW = 10;
	localparam int IdxW   = 2;
	localparam int InW    = 40;
	localparam int OutW   = 24;

	localparam logic [IdxW-1:0] REG_PRE_ALARM = 2'd0;
	localparam logic [IdxW-1:0] REG_MESSAGE   = 2'd1;
	localparam logic [IdxW-1:0] REG_DISP_TO   = 2'd2;

	localparam logic [PreW-1:0]  PRE_RESET  = 20'd10000;
	localparam logic [MsgW-1:0]  MSG_RESET  = 20'd2000;
	localparam logic [DispW-1:0] DISP_RESET = 22'd15000;

	localparam logic [NowW-1:0] DEBOUNCE_MS = 32'd30;
	localparam logic [PreW:0]   ROUND_UP    = 21'd999;

	// Seconds: n / 1000 = (n >> 3) / 125, reciprocal of 125 scaled by 2^25.
	localparam int              NumW     = PreW + 1;
	localparam int              SecXW    = NumW - 3;
	localparam int              SecMW    = 19;
	localparam int              SecShift = 25;
	localparam int              SecQW    = 12;
	localparam logic [SecMW-1:0] SEC_RECIP = 19'd268436;
	localparam logic [SecQW-1:0] COUNT_MAX = 12'd1023;

	// Blink: now / 400 = (now >> 4) / 25, reciprocal of 25 scaled by 2^33.
	localparam int               BlkXW     = NowW - 4;
	localparam int               BlkMW     = 29;
	localparam int               BlkShift  = 33;
	localparam logic [BlkMW-1:0] BLK_RECIP = 29'd343597384;

endpackage

@@ rtl/core/fall_alarm_sequencer.sv @@
// Top level of the fall alarm sequencer: mode control, debounce, display timeout and outputs.
//
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: poll item
// m_axis    out  m_tvalid/m_tready  m_tdata: result item
// cfg       in   cfg_we             cfg_index, cfg_wdata
//
// One item is accepted per cycle unless the output stalls, and each gives one result.
// The mode and timer state updates in the first stage, so items chain each cycle unless stalled.
// The second stage holds the reciprocal multiplies for the seconds count and the blink phase.
// Each stage has its own valid bit, so input flows while a result waits until the stages fill.
// Reset is asynchronous and active low and restores the power-up modes and registers.
module fall_alarm_sequencer
	import fas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// now_ms[31:0], fall_detected[32], button_level[33], touch_level[34], zero fill.
	input  logic [InW-1:0]   s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// mode[1:0], entered_prealarm[2], alarm_started[3], alarm_stopped[4], cancel_shown[5],
	// back_to_normal[6], display_enabled[7], display_woken[8], countdown_s[18:9],
	// blink_on[19], zero fill.
	output logic [OutW-1:0]  m_tdata,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]  cfg_wdata
);

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_PRE    = 2'd1,
		MODE_ALARM  = 2'd2,
		MODE_MSG    = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  e_pre;
		logic  a_start;
		logic  a_stop;
		logic  cancel;
		logic  back;
		logic  power;
		logic  woken;
	} flags_t;

	logic [PreW-1:0]  pre_q;
	logic [MsgW-1:0]  msg_q;
	logic [DispW-1:0] disp_q;

	mode_t           mode_q;
	logic [NowW-1:0] entry_q;
	logic            power_q;
	logic [NowW-1:0] act_q;
	logic            last_q;
	logic            stable_q;
	logic [NowW-1:0] change_q;

	logic            valid_s1;
	logic [NowW-1:0] now_s1;
	logic            fall_s1;
	logic            btn_s1;
	logic            touch_s1;

	logic              valid_s2;
	flags_t            flags_s2;
	logic              cnt_en_s2;
	logic [NumW-1:0]   num_s2;
	logic              blk_en_s2;
	logic [BlkXW-1:0]  blkx_s2;

	logic            out_valid_q;
	logic [OutW-1:0] out_data_q;

	logic ready_s1, ready_s2, ready_out, fire_s1;

	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign fire_s1   = valid_s1 && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q  <= PRE_RESET;
			msg_q  <= MSG_RESET;
			disp_q <= DISP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRE_ALARM: pre_q  <= cfg_wdata[PreW-1:0];
				REG_MESSAGE:   msg_q  <= cfg_wdata[MsgW-1:0];
				REG_DISP_TO:   disp_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			now_s1   <= s_tdata[NowW-1:0];
			fall_s1  <= s_tdata[NowW];
			btn_s1   <= s_tdata[NowW+1];
			touch_s1 <= s_tdata[NowW+2];
		end
	end

	logic [NowW-1:0] d_s1, since_s1, idle_s1;
	logic            press_s1, stable_d, dbn_on;
	logic [NowW-1:0] change_d;
	mode_t           mode_d;
	logic [NowW-1:0] entry_d, act_d;
	logic            power_d;
	flags_t          flags_d;
	logic            cnt_en_d, blk_en_d;
	logic [NumW-1:0] num_d;

	always_comb begin
		d_s1     = now_s1 - entry_q;
		idle_s1  = now_s1 - act_q;
		dbn_on   = (mode_q != MODE_NORMAL);
		change_d = (btn_s1 != last_q) ? now_s1 : change_q;
		since_s1 = (btn_s1 != last_q) ? '0 : (now_s1 - change_q);
		stable_d = stable_q;
		press_s1 = 1'b0;
		if ((since_s1 > DEBOUNCE_MS) && (btn_s1 != stable_q)) begin
			stable_d = btn_s1;
			press_s1 = !btn_s1;
		end

		mode_d   = mode_q;
		entry_d  = entry_q;
		act_d    = act_q;
		power_d  = power_q;
		flags_d  = '0;
		cnt_en_d = 1'b0;
		blk_en_d = 1'b0;
		num_d    = {1'b0, pre_q};

		case (mode_q)
			MODE_NORMAL: begin
				if (fall_s1) begin
					flags_d.e_pre = 1'b1;
					power_d       = 1'b1;
					cnt_en_d      = 1'b1;
					entry_d       = now_s1;
					mode_d        = MODE_PRE;
				end else if (touch_s1) begin
					power_d       = 1'b1;
					flags_d.woken = !power_q;
					act_d         = now_s1;
				end else if (power_q && (disp_q != '0) &&
						(idle_s1 > {{(NowW-DispW){1'b0}}, disp_q})) begin
					power_d = 1'b0;
				end
			end
			MODE_PRE: begin
				if (d_s1 < {{(NowW-PreW){1'b0}}, pre_q}) begin
					cnt_en_d = 1'b1;
					num_d    = {1'b0, pre_q} - {1'b0, d_s1[PreW-1:0]} + ROUND_UP;
				end
				if (press_s1 || touch_s1) begin
					flags_d.cancel = 1'b1;
					mode_d         = MODE_MSG;
					entry_d        = now_s1;
				end else if (d_s1 >= {{(NowW-PreW){1'b0}}, pre_q}) begin
					flags_d.a_start = 1'b1;
					mode_d          = MODE_ALARM;
				end
			end
			MODE_ALARM: begin
				blk_en_d = 1'b1;
				if (press_s1) begin
					flags_d.a_stop = 1'b1;
					flags_d.cancel = 1'b1;
					mode_d         = MODE_MSG;
					entry_d        = now_s1;
				end
			end
			default: begin
				if (d_s1 >= {{(NowW-MsgW){1'b0}}, msg_q}) begin
					power_d      = 1'b1;
					act_d        = now_s1;
					mode_d       = MODE_NORMAL;
					flags_d.back = 1'b1;
				end
			end
		endcase
		flags_d.mode  = mode_d;
		flags_d.power = power_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			entry_q  <= '0;
			power_q  <= 1'b1;
			act_q    <= '0;
			last_q   <= 1'b1;
			stable_q <= 1'b1;
			change_q <= '0;
		end else if (fire_s1) begin
			mode_q  <= mode_d;
			entry_q <= entry_d;
			power_q <= power_d;
			act_q   <= act_d;
			if (dbn_on) begin
				last_q   <= btn_s1;
				stable_q <= stable_d;
				change_q <= change_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			flags_s2  <= flags_d;
			cnt_en_s2 <= cnt_en_d;
			num_s2    <= num_d;
			blk_en_s2 <= blk_en_d;
			blkx_s2   <= now_s1[NowW-1:4];
		end
	end

	logic [SecXW+SecMW-1:0] sec_prod;
	logic [BlkXW+BlkMW-1:0] blk_prod;
	logic [SecQW-1:0]       sec_q;
	logic [CountW-1:0]      count_s2;
	logic                   blink_s2;

	always_comb begin
		sec_prod = {{SecMW{1'b0}}, num_s2[NumW-1:3]} * {{SecXW{1'b0}}, SEC_RECIP};
		blk_prod = {{BlkMW{1'b0}}, blkx_s2} * {{BlkXW{1'b0}}, BLK_RECIP};
		sec_q    = sec_prod[SecShift +: SecQW];
		if (!cnt_en_s2) begin
			count_s2 = '0;
		end else if (sec_q > COUNT_MAX) begin
			count_s2 = COUNT_MAX[CountW-1:0];
		end else begin
			count_s2 = sec_q[CountW-1:0];
		end
		blink_s2 = blk_en_s2 && !blk_prod[BlkShift];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			out_data_q <= {4'b0, blink_s2, count_s2, flags_s2.woken, flags_s2.power,
				flags_s2.back, flags_s2.cancel, flags_s2.a_stop, flags_s2.a_start,
				flags_s2.e_pre, flags_s2.mode};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_stop_cancels: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[4]) |-> (m_tdata[5] && (m_tdata[1:0] == MODE_MSG)))
		else $error("alarm stop without cancel message");

	a_alarm_no_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (mode_q == MODE_ALARM)) |-> (mode_d == MODE_ALARM || mode_d == MODE_MSG))
		else $error("alarm left without a button stop");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(mode_q) && $stable(entry_q) && $stable(power_q)))
		else $error("mode state moved without an item");

	a_pulses_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0({flags_s2.e_pre, flags_s2.a_start, flags_s2.back,
			flags_s2.woken, flags_s2.cancel}))
		else $error("more than one transition pulse in one item");

	a_blink_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[19]) |-> (m_tdata[1:0] == MODE_ALARM || m_tdata[1:0] == MODE_MSG))
		else $error("blink outside alarm");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fall alarm sequencer: directed mode walks, then random polls.
module testbench;
	import fas_pkg::*;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_PREALARM,
		MODE_ALARM,
		MODE_MESSAGE
	} mode_t;

	typedef struct packed {
		logic        touch_level;
		logic        button_level;
		logic        fall_detected;
		logic [31:0] now_ms;
	} poll_t;

	typedef struct packed {
		logic [3:0]        fill;
		logic              blink_on;
		logic [CountW-1:0] countdown_s;
		logic              display_woken;
		logic              display_enabled;
		logic              back_to_normal;
		logic              cancel_shown;
		logic              alarm_stopped;
		logic              alarm_started;
		logic              entered_prealarm;
		logic [1:0]        mode;
	} result_t;

	localparam logic [31:0] BLINK_MS   = 32'd400;
	localparam logic [31:0] MS_PER_S   = 32'd1000;
	localparam int          PIPE_DEPTH = 3;
	localparam int          MAX_PRINTS = 20;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [InW-1:0]   s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OutW-1:0]  m_tdata;
	logic             cfg_we    = 1'b0;
	logic [IdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]  cfg_wdata = '0;

	// Predicted configuration and sequencer state.
	logic [PreW-1:0]  pre_alarm_len    = PRE_RESET;
	logic [MsgW-1:0]  message_len      = MSG_RESET;
	logic [DispW-1:0] idle_limit       = DISP_RESET;
	mode_t            seq_mode         = MODE_NORMAL;
	logic [31:0]      entry_stamp      = '0;
	logic             screen_on        = 1'b1;
	logic [31:0]      activity_stamp   = '0;
	logic             btn_sampled      = 1'b1;
	logic             btn_settled      = 1'b1;
	logic [31:0]      btn_change_stamp = '0;

	result_t expected_results[$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	logic [31:0] clock_ms = '0;
	logic button_held = 1'b1;

	int polls_sent      = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int prealarms_seen  = 0;
	int alarms_seen     = 0;
	int stops_seen      = 0;
	int cancels_seen    = 0;

	fall_alarm_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic button_press(logic [31:0] now, logic raw);
		logic [31:0] held;
		if (raw != btn_sampled) begin
			btn_sampled = raw;
			btn_change_stamp = now;
		end
		held = now - btn_change_stamp;
		if (held > DEBOUNCE_MS && raw != btn_settled) begin
			btn_settled = raw;
			return !raw;
		end
		return 1'b0;
	endfunction

	function automatic logic [CountW-1:0] whole_seconds(logic [31:0] ms);
		logic [31:0] secs;
		secs = ms / MS_PER_S;
		return (secs > COUNT_MAX) ? COUNT_MAX[CountW-1:0] : secs[CountW-1:0];
	endfunction

	function automatic result_t predict_poll(poll_t p);
		result_t r;
		logic [31:0] since_entry;
		logic [31:0] since_activity;
		logic [31:0] blink_periods;
		logic pressed;
		r = '0;
		since_entry = p.now_ms - entry_stamp;
		case (seq_mode)
		MODE_NORMAL: begin
			if (p.fall_detected) begin
				r.entered_prealarm = 1'b1;
				screen_on = 1'b1;
				r.countdown_s = whole_seconds({12'd0, pre_alarm_len});
				entry_stamp = p.now_ms;
				seq_mode = MODE_PREALARM;
			end else begin
				if (p.touch_level) begin
					if (!screen_on) begin
						screen_on = 1'b1;
						r.display_woken = 1'b1;
					end
					activity_stamp = p.now_ms;
				end
				since_activity = p.now_ms - activity_stamp;
				if (screen_on && idle_limit != '0 && since_activity > {10'd0, idle_limit})
					screen_on = 1'b0;
			end
		end
		MODE_PREALARM: begin
			pressed = button_press(p.now_ms, p.button_level);
			if (since_entry < {12'd0, pre_alarm_len})
				r.countdown_s = whole_seconds({12'd0, pre_alarm_len} - since_entry + ROUND_UP);
			if (pressed || p.touch_level) begin
				r.cancel_shown = 1'b1;
				seq_mode = MODE_MESSAGE;
				entry_stamp = p.now_ms;
			end else if (since_entry >= {12'd0, pre_alarm_len}) begin
				r.alarm_started = 1'b1;
				seq_mode = MODE_ALARM;
			end
		end
		MODE_ALARM: begin
			blink_periods = p.now_ms / BLINK_MS;
			r.blink_on = ~blink_periods[0];
			if (button_press(p.now_ms, p.button_level)) begin
				r.alarm_stopped = 1'b1;
				r.cancel_shown = 1'b1;
				seq_mode = MODE_MESSAGE;
				entry_stamp = p.now_ms;
			end
		end
		default: begin
			pressed = button_press(p.now_ms, p.button_level);
			if (since_entry >= {12'd0, message_len}) begin
				screen_on = 1'b1;
				activity_stamp = p.now_ms;
				seq_mode = MODE_NORMAL;
				r.back_to_normal = 1'b1;
			end
		end
		endcase
		r.mode = seq_mode;
		r.display_enabled = screen_on;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
				results_checked, name, got, want));
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with no poll pending: %h", m_tdata));
			end else begin
				want = expected_results.pop_front();
				check_field("mode", got.mode, want.mode);
				check_field("entered_prealarm", got.entered_prealarm, want.entered_prealarm);
				check_field("alarm_started", got.alarm_started, want.alarm_started);
				check_field("alarm_stopped", got.alarm_stopped, want.alarm_stopped);
				check_field("cancel_shown", got.cancel_shown, want.cancel_shown);
				check_field("back_to_normal", got.back_to_normal, want.back_to_normal);
				check_field("display_enabled", got.display_enabled, want.display_enabled);
				check_field("display_woken", got.display_woken, want.display_woken);
				check_field("countdown_s", got.countdown_s, want.countdown_s);
				check_field("blink_on", got.blink_on, want.blink_on);
				check_field("fill", got.fill, want.fill);
			end
			results_checked++;
		end
	end

	task automatic send_poll(poll_t p);
		result_t r;
		@(negedge clk);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(InW - $bits(poll_t)){1'b0}}, p};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_poll(p);
		expected_results.push_back(r);
		polls_sent++;
		prealarms_seen += r.entered_prealarm;
		alarms_seen += r.alarm_started;
		stops_seen += r.alarm_stopped;
		cancels_seen += r.cancel_shown;
	endtask

	task automatic poll_at(logic [31:0] now, logic fall, logic button, logic touch);
		poll_t p;
		p.now_ms = now;
		p.fall_detected = fall;
		p.button_level = button;
		p.touch_level = touch;
		clock_ms = now;
		button_held = button;
		send_poll(p);
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	task automatic write_register(logic [IdxW-1:0] idx, logic [CfgW-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_PRE_ALARM: pre_alarm_len = value[PreW-1:0];
		REG_MESSAGE:   message_len = value[MsgW-1:0];
		REG_DISP_TO:   idle_limit = value[DispW-1:0];
		default: ;
		endcase
	endtask

	task automatic test_display_timeout();
		poll_at(32'd0, 1'b0, 1'b1, 1'b0);
		poll_at(32'd15001, 1'b0, 1'b1, 1'b0);
		poll_at(32'd15002, 1'b0, 1'b1, 1'b1);
		poll_at(32'd15003, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_prealarm_cancel();
		// A touch during the fall poll is ignored.
		poll_at(32'd15010, 1'b1, 1'b1, 1'b1);
		poll_at(32'd15500, 1'b0, 1'b1, 1'b0);
		poll_at(32'd16000, 1'b0, 1'b0, 1'b0);
		poll_at(32'd16031, 1'b0, 1'b0, 1'b0);
		poll_at(32'd17000, 1'b0, 1'b1, 1'b0);
		poll_at(32'd18031, 1'b0, 1'b1, 1'b0);
		poll_at(32'd18040, 1'b1, 1'b1, 1'b0);
		poll_at(32'd18100, 1'b0, 1'b1, 1'b1);
		poll_at(32'd20100, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_alarm_stop();
		poll_at(32'd20200, 1'b1, 1'b1, 1'b0);
		poll_at(32'd30200, 1'b0, 1'b1, 1'b0);
		poll_at(32'd30300, 1'b0, 1'b1, 1'b1);
		poll_at(32'd30400, 1'b0, 1'b0, 1'b0);
		poll_at(32'd30430, 1'b0, 1'b0, 1'b0);
		poll_at(32'd30431, 1'b0, 1'b0, 1'b0);
		poll_at(32'd32431, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_config_extremes();
		settle();
		write_register(REG_PRE_ALARM, '0);
		write_register(REG_MESSAGE, '0);
		write_register(REG_DISP_TO, '0);
		poll_at(32'd40000, 1'b1, 1'b1, 1'b0);
		poll_at(32'd40001, 1'b0, 1'b1, 1'b0);
		poll_at(32'd40010, 1'b0, 1'b0, 1'b0);
		poll_at(32'd40041, 1'b0, 1'b0, 1'b0);
		poll_at(32'd40042, 1'b0, 1'b0, 1'b0);
		poll_at(32'hEE6B_2800, 1'b0, 1'b1, 1'b0);
		settle();
		write_register(REG_PRE_ALARM, 22'h0F_FFFF);
		write_register(REG_MESSAGE, 22'h0F_FFFF);
		write_register(REG_DISP_TO, 22'h3F_FFFF);
		// The countdown saturates, and the timestamp wraps past zero.
		poll_at(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0);
		poll_at(32'd5, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_random_polls(int idle_pct, int stall_pct, int count);
		poll_t p;
		int roll;
		settle();
		write_register(REG_PRE_ALARM, CfgW'($urandom_range(800, 100)));
		write_register(REG_MESSAGE, CfgW'($urandom_range(300, 30)));
		write_register(REG_DISP_TO, CfgW'($urandom_range(1500, 100)));
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		clock_ms = $urandom();
		repeat (count) begin
			roll = $urandom_range(99, 0);
			if (roll < 4) begin
				p.now_ms = $urandom();
				p.fall_detected = 1'($urandom_range(1, 0));
				p.button_level = 1'($urandom_range(1, 0));
				p.touch_level = 1'($urandom_range(1, 0));
				clock_ms = p.now_ms;
			end else begin
				if (roll < 10)
					clock_ms += $urandom_range(3000, 0);
				else
					clock_ms += $urandom_range(40, 1);
				// The button level mostly holds for several polls so presses get through.
				if ($urandom_range(7, 0) == 0)
					button_held = ~button_held;
				p.now_ms = clock_ms;
				p.button_level = button_held;
				case (seq_mode)
				MODE_NORMAL: begin
					p.fall_detected = ($urandom_range(99, 0) < 8);
					p.touch_level = ($urandom_range(99, 0) < 15);
				end
				MODE_PREALARM: begin
					p.fall_detected = 1'($urandom_range(1, 0));
					p.touch_level = ($urandom_range(99, 0) < 4);
				end
				default: begin
					p.fall_detected = 1'($urandom_range(1, 0));
					p.touch_level = ($urandom_range(99, 0) < 30);
				end
				endcase
			end
			send_poll(p);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_display_timeout();
		test_prealarm_cancel();
		test_alarm_stop();
		test_config_extremes();
		test_random_polls(0, 0, 230);
		test_random_polls(75, 0, 230);
		test_random_polls(0, 75, 230);
		test_random_polls(38, 38, 230);

		settle();
		repeat (20) @(negedge clk);
		$display("Checked %0d results from %0d polls across four idling phases.",
			results_checked, polls_sent);
		$display("Seen %0d pre-alarms, %0d alarms, %0d button stops and %0d cancel messages.",
			prealarms_seen, alarms_seen, stops_seen, cancels_seen);
		if (mismatches == 0)
			$display("fall_alarm_sequencer verification clean");
		else
			$display("fall_alarm_sequencer verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Run timed out with %0d results outstanding.", expected_results.size());
		$display("fall_alarm_sequencer verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/fas_pkg.sv
rtl/core/fall_alarm_sequencer.sv
tb/sv/testbench.sv
